// File: src/max_xor_binary_trie_core_assert.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef MAX_XOR_BINARY_TRIE_CORE_ASSERT_SVH
`define MAX_XOR_BINARY_TRIE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MXT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MXT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mxt_pkg.sv
// shared types and constants for the max-xor binary trie core
// no dependencies
package mxt_pkg;

   localparam int KEY_BITS   = 31;
   localparam int NODE_POOL  = 4096;
   localparam int COUNT_BITS = 16;
   localparam int NODE_BITS  = $clog2(NODE_POOL);
   localparam int USED_BITS  = NODE_BITS + 1;
   localparam int LEVEL_BITS = $clog2(KEY_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(KEY_BITS - 1);
   localparam logic [USED_BITS:0]    POOL_LIMIT = (USED_BITS + 1)'(NODE_POOL - 1);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_POOL     = 2'd1,
      ST_ABSENT   = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]  child;
      logic [COUNT_BITS-1:0] count;
   } edge_type;

   // one row per node: both outgoing edges, indexed by bit value
   typedef edge_type [1:0] row_type;

   typedef struct packed {
      logic                 en;
      logic [NODE_BITS-1:0] addr;
      row_type              data;
   } wr_req_type;

endpackage

// File: src/max_xor_binary_trie_core.sv
// max-xor binary trie core: insert, delete and max-xor query over a counted trie
// depends on mxt_pkg and mxt_node_ram
//
// After reset the node table is cleared one row per cycle, all 4096 rows, with
// req_stall high. Each item walks the trie one level per node table read. A
// query on an empty trie stops at the root. An insert or delete first checks
// its path and then updates it; a refused delete ends at the level where the
// check fails, a refused insert where its scan stops. A kind of 3 returns zero
// with status ok. One item is worked on at a time; the next is accepted while
// the previous result still waits in the output register, and a finished item
// waits in its last cycle for as long as that register is full and stalled.
module max_xor_binary_trie_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [mxt_pkg::KEY_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mxt_pkg::KEY_BITS-1:0] rsp_best_xor,
   output logic [1:0]                   rsp_status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type                          state_ff;
   logic [mxt_pkg::NODE_BITS-1:0]      clr_addr_ff;
   logic [mxt_pkg::NODE_BITS-1:0]      node_ff;
   logic [mxt_pkg::LEVEL_BITS-1:0]     level_ff;
   mxt_pkg::kind_type                  kind_ff;
   logic [mxt_pkg::KEY_BITS-1:0]       key_ff;
   logic [mxt_pkg::KEY_BITS-1:0]       best_ff;
   mxt_pkg::status_type                status_ff;
   logic                               ovf_ff;
   logic [mxt_pkg::USED_BITS-1:0]      nodes_used_ff;
   logic                               rsp_valid_ff;
   logic [mxt_pkg::KEY_BITS-1:0]       rsp_best_xor_ff;
   mxt_pkg::status_type                rsp_status_ff;

   mxt_pkg::row_type                   rd_row;
   mxt_pkg::wr_req_type                wr_req;
   logic [mxt_pkg::NODE_BITS-1:0]      rd_addr;

   logic                               bit_sel;
   mxt_pkg::edge_type                  cur_edge;
   mxt_pkg::edge_type                  opp_edge;
   mxt_pkg::edge_type                  mod_edge;
   mxt_pkg::row_type                   mod_row;
   logic                               cur_missing;
   logic                               cnt_max;
   logic                               root_empty;
   logic [mxt_pkg::USED_BITS-1:0]      alloc_idx;
   logic [mxt_pkg::LEVEL_BITS:0]       needed;
   logic [mxt_pkg::USED_BITS:0]        pool_sum;
   logic                               pool_full;
   logic                               ovf_fin;
   logic                               scan_stop;
   logic [mxt_pkg::NODE_BITS-1:0]      next_node;
   logic                               out_free;

   always_comb begin
      bit_sel     = key_ff[level_ff];
      cur_edge    = rd_row[bit_sel];
      opp_edge    = rd_row[~bit_sel];
      cur_missing = (cur_edge.child == '0);
      cnt_max     = (cur_edge.count == mxt_pkg::COUNT_MAX);
      root_empty  = (rd_row[0].count == '0) && (rd_row[1].count == '0);
      alloc_idx   = nodes_used_ff + mxt_pkg::USED_BITS'(1);

      // nodes still to allocate from the first missing child down
      needed    = cur_missing ? ((mxt_pkg::LEVEL_BITS + 1)'(level_ff) + 1'b1) : '0;
      pool_sum  = (mxt_pkg::USED_BITS + 1)'(nodes_used_ff) + (mxt_pkg::USED_BITS + 1)'(needed);
      pool_full = (pool_sum > mxt_pkg::POOL_LIMIT);
      ovf_fin   = ovf_ff || (!cur_missing && cnt_max);

      mod_edge = cur_edge;
      if (kind_ff == mxt_pkg::KIND_INSERT) begin
         if (cur_missing) begin
            mod_edge.child = alloc_idx[mxt_pkg::NODE_BITS-1:0];
         end
         mod_edge.count = cur_edge.count + 1'b1;
      end else begin
         mod_edge.count = cur_edge.count - 1'b1;
      end
      mod_row          = rd_row;
      mod_row[bit_sel] = mod_edge;

      scan_stop = (level_ff == '0);
      next_node = cur_edge.child;
      if (state_ff == S_SCAN) begin
         unique case (kind_ff)
            mxt_pkg::KIND_INSERT: scan_stop = scan_stop || cur_missing;
            mxt_pkg::KIND_DELETE: scan_stop = scan_stop || cur_missing ||
                                              (cur_edge.count == '0);
            mxt_pkg::KIND_QUERY: begin
               scan_stop = scan_stop || ((level_ff == mxt_pkg::TOP_LEVEL) && root_empty);
               if (opp_edge.count != '0) begin
                  next_node = opp_edge.child;
               end
            end
            default: scan_stop = 1'b1;
         endcase
      end else if (state_ff == S_COMMIT) begin
         next_node = mod_edge.child;
      end

      // a finished walk reads the root again for the next pass
      if (((state_ff == S_SCAN) || (state_ff == S_COMMIT)) && !scan_stop) begin
         rd_addr = next_node;
      end else begin
         rd_addr = '0;
      end

      wr_req.en   = (state_ff == S_CLEAR) || (state_ff == S_COMMIT);
      wr_req.addr = (state_ff == S_CLEAR) ? clr_addr_ff : node_ff;
      wr_req.data = (state_ff == S_CLEAR) ? '0 : mod_row;

      out_free = !rsp_valid_ff || !rsp_stall;
   end

   mxt_node_ram u_ram (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         nodes_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // in S_DONE the output register is handled below
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= mxt_pkg::kind_type'(req_kind);
                  key_ff    <= req_value;
                  level_ff  <= mxt_pkg::TOP_LEVEL;
                  node_ff   <= '0;
                  best_ff   <= '0;
                  status_ff <= mxt_pkg::ST_OK;
                  ovf_ff    <= 1'b0;
                  if (mxt_pkg::kind_type'(req_kind) == mxt_pkg::KIND_NONE) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               unique case (kind_ff)
                  mxt_pkg::KIND_INSERT: begin
                     ovf_ff <= ovf_fin;
                     if (scan_stop) begin
                        // pool check takes precedence over count overflow
                        priority if (pool_full) begin
                           status_ff <= mxt_pkg::ST_POOL;
                           state_ff  <= S_DONE;
                        end else if (ovf_fin) begin
                           status_ff <= mxt_pkg::ST_OVERFLOW;
                           state_ff  <= S_DONE;
                        end else begin
                           level_ff <= mxt_pkg::TOP_LEVEL;
                           node_ff  <= '0;
                           state_ff <= S_COMMIT;
                        end
                     end
                  end
                  mxt_pkg::KIND_DELETE: begin
                     if (cur_missing || (cur_edge.count == '0)) begin
                        status_ff <= mxt_pkg::ST_ABSENT;
                        state_ff  <= S_DONE;
                     end else if (scan_stop) begin
                        level_ff <= mxt_pkg::TOP_LEVEL;
                        node_ff  <= '0;
                        state_ff <= S_COMMIT;
                     end
                  end
                  mxt_pkg::KIND_QUERY: begin
                     if ((level_ff == mxt_pkg::TOP_LEVEL) && root_empty) begin
                        state_ff <= S_DONE;
                     end else begin
                        if (opp_edge.count != '0) begin
                           best_ff[level_ff] <= 1'b1;
                        end
                        if (scan_stop) begin
                           state_ff <= S_DONE;
                        end
                     end
                  end
                  default: state_ff <= S_DONE;
               endcase
               if (!scan_stop) begin
                  level_ff <= level_ff - 1'b1;
                  node_ff  <= next_node;
               end
            end
            S_COMMIT: begin
               if ((kind_ff == mxt_pkg::KIND_INSERT) && cur_missing) begin
                  nodes_used_ff <= alloc_idx;
               end
               if (scan_stop) begin
                  state_ff <= S_DONE;
               end else begin
                  level_ff <= level_ff - 1'b1;
                  node_ff  <= next_node;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_best_xor_ff <= best_ff;
                  rsp_status_ff   <= status_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_xor = rsp_best_xor_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// File: src/mxt_node_ram.sv
// node table: one row of two counted edges per trie node
// one write port, one registered read port; uses mxt_pkg
module mxt_node_ram (
   input  logic                         clock,
   input  mxt_pkg::wr_req_type          wr_req,
   input  logic [mxt_pkg::NODE_BITS-1:0] rd_addr,
   output mxt_pkg::row_type             rd_row
);

   mxt_pkg::row_type mem [mxt_pkg::NODE_POOL];
   mxt_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_row = rd_data_ff;

endmodule

// File: src/mxt_checker.sv
// port-level checks for the max-xor binary trie core, bound to the top level
// depends on mxt_pkg and max_xor_binary_trie_core_assert.svh
`include "max_xor_binary_trie_core_assert.svh"

module mxt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_kind,
   input logic [mxt_pkg::KEY_BITS-1:0] req_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [mxt_pkg::KEY_BITS-1:0] rsp_best_xor,
   input logic [1:0]                   rsp_status
);

   logic req_take;
   logic req_hold;
   logic rsp_hold;

   assign req_take = req_valid && !req_stall;
   assign req_hold = req_valid && req_stall;
   assign rsp_hold = rsp_valid && rsp_stall;

   // a stalled result item stays offered and unchanged
   `MXT_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_hold, rsp_valid,
                    "rsp_valid dropped while stalled")
   `MXT_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_hold,
                    $stable(rsp_best_xor) && $stable(rsp_status),
                    "rsp payload changed while stalled")
   // a stalled input item stays offered and unchanged
   `MXT_ASSERT_NEXT(a_req_payload_holds, clock, reset, req_hold,
                    req_valid && $stable(req_kind) && $stable(req_value),
                    "req item changed while stalled")
   // an accepted item keeps the core busy for at least the next cycle
   `MXT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall,
                    "core ready right after accepting an item")
   // only a query produces a nonzero xor, and queries never fail
   `MXT_ASSERT_SAME(a_xor_means_ok, clock, reset, rsp_valid && (rsp_best_xor != '0),
                    rsp_status == mxt_pkg::ST_OK, "nonzero best_xor with failing status")

endmodule

bind max_xor_binary_trie_core mxt_checker u_mxt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_best_xor (rsp_best_xor),
   .rsp_status   (rsp_status)
);
